// ===== rtl/ipc_pkg.sv =====
// ----------------------------------------------------------------------------
// Isolated pixel counter package
// Shared sizes and limits for the isolated pixel counter and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ipc_pkg;

   // largest supported image side
   localparam int MAX_SIZE     = 128;
   // column and row index width
   localparam int POS_W        = $clog2(MAX_SIZE);
   // size register width
   localparam int CSR_W        = 8;
   // tally width and saturation limit
   localparam int TALLY_W      = 14;
   localparam int TALLY_MAX    = (1 << TALLY_W) - 1;
   // number of interior pixels of the largest image
   localparam int MAX_INTERIOR = (MAX_SIZE - 2) * (MAX_SIZE - 2);
   // stream payload widths
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = ((2 * TALLY_W + 7) / 8) * 8;

endpackage : ipc_pkg

`default_nettype wire

// ===== rtl/ipc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data, no reset on contents.
// ----------------------------------------------------------------------------
`default_nettype none

module ipc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : ipc_ram

`default_nettype wire

// ===== rtl/isolated_pixel_counter.sv =====
// ----------------------------------------------------------------------------
// Isolated pixel counter
// Counts isolated zeros and ones of a square binary image, 4-neighbourhood.
// ----------------------------------------------------------------------------
// The block takes one pixel per request in raster order and accepts one
// request every clock cycle. Each interior pixel is judged in the cycle that
// takes the pixel diagonally below-right of it; the request that carries
// the last pixel of the image produces one response with both counts, which
// appears in the next cycle. Rate is set by the line buffer: a single RAM
// holds the two previous rows and is read one column ahead, so one pixel per
// cycle is sustained. Pixel input stalls only when the last pixel of an
// image arrives while the previous response has not yet been taken. Writing
// csr_wr_data sets the side length (0 reads as 1, values above 128 as 128)
// and restarts the image; write it only while the block is idle.
`default_nettype none

module isolated_pixel_counter (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration
   input  wire logic                            csr_wr_en,
   input  wire logic [ipc_pkg::CSR_W-1:0]       csr_wr_data,  // [7:0] image_size
   // pixel requests
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [ipc_pkg::REQ_DATA_W-1:0]  req_tdata,    // [0] pixel, rest zero
   // count responses
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [13:0] isolated_zero_count, [27:14] isolated_one_count, rest zero
   output logic [ipc_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   localparam int PW = ipc_pkg::POS_W;
   localparam int TW = ipc_pkg::TALLY_W;

   logic [PW-1:0] size_m1_ff, size_m1_in;
   logic [PW-1:0] col_ff, col_in;
   logic [PW-1:0] row_ff, row_in;
   logic [TW-1:0] zero_ff, zero_in;
   logic [TW-1:0] one_ff, one_in;
   logic          prev_ff, c1_ff, c2_ff, a1_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0] rsp_zero_ff, rsp_one_ff;

   logic          accept;
   logic          col_last, row_last, img_last;
   logic          judge;
   logic          old_above, old_center;
   logic [1:0]    buf_rd, buf_wr;
   logic          iso_zero, iso_one;
   logic [TW-1:0] zero_nxt, one_nxt;
   logic          pixel;

   assign pixel    = req_tdata[0];
   assign col_last = (col_ff == size_m1_ff);
   assign row_last = (row_ff == size_m1_ff);
   assign img_last = col_last && row_last;

   // hold off only the last pixel while the previous response still waits
   assign req_tready = !rsp_valid_ff || rsp_tready || !img_last;
   assign accept     = req_tvalid && req_tready;

   // line buffer: bit 1 row two above, bit 0 row just above
   assign old_above  = buf_rd[1];
   assign old_center = buf_rd[0];
   assign buf_wr     = {old_center, pixel};

   ipc_ram #(
      .WIDTH (2),
      .DEPTH (ipc_pkg::MAX_SIZE)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (buf_wr),
      .rd_addr (col_in),
      .rd_data (buf_rd)
   );

   // judge the pixel one up and one left of the incoming one
   assign judge    = (row_ff > PW'(1)) && (col_ff > PW'(1));
   assign iso_zero = judge && !c1_ff && c2_ff && old_center && a1_ff && prev_ff;
   assign iso_one  = judge && c1_ff && !c2_ff && !old_center && !a1_ff && !prev_ff;

   // saturating tallies
   always_comb begin
      zero_nxt = zero_ff;
      one_nxt  = one_ff;
      if (iso_zero && (zero_ff != TW'(ipc_pkg::TALLY_MAX))) begin
         zero_nxt = zero_ff + TW'(1);
      end
      if (iso_one && (one_ff != TW'(ipc_pkg::TALLY_MAX))) begin
         one_nxt = one_ff + TW'(1);
      end
   end

   // clamp the written size and keep it as size minus one
   always_comb begin
      size_m1_in = size_m1_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            size_m1_in = '0;
         end else if (int'(csr_wr_data) > ipc_pkg::MAX_SIZE) begin
            size_m1_in = PW'(ipc_pkg::MAX_SIZE - 1);
         end else begin
            size_m1_in = PW'(csr_wr_data - 8'd1);
         end
      end
   end

   // advance positions and tallies
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      zero_in = zero_ff;
      one_in  = one_ff;
      if (csr_wr_en) begin
         col_in  = '0;
         row_in  = '0;
         zero_in = '0;
         one_in  = '0;
      end else if (accept) begin
         zero_in = zero_nxt;
         one_in  = one_nxt;
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in  = '0;
               zero_in = '0;
               one_in  = '0;
            end else begin
               row_in = row_ff + PW'(1);
            end
         end else begin
            col_in = col_ff + PW'(1);
         end
      end
   end

   // response handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && img_last && !csr_wr_en) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         size_m1_ff   <= PW'(ipc_pkg::MAX_SIZE - 1);
         col_ff       <= '0;
         row_ff       <= '0;
         zero_ff      <= '0;
         one_ff       <= '0;
         prev_ff      <= 1'b0;
         c1_ff        <= 1'b0;
         c2_ff        <= 1'b0;
         a1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_m1_ff   <= size_m1_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         zero_ff      <= zero_in;
         one_ff       <= one_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            prev_ff <= 1'b0;
            c1_ff   <= 1'b0;
            c2_ff   <= 1'b0;
            a1_ff   <= 1'b0;
         end else if (accept) begin
            prev_ff <= pixel;
            c1_ff   <= old_center;
            c2_ff   <= c1_ff;
            a1_ff   <= old_above;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept && img_last) begin
         rsp_zero_ff <= zero_nxt;
         rsp_one_ff  <= one_nxt;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(ipc_pkg::RSP_DATA_W - 2 * TW){1'b0}}, rsp_one_ff, rsp_zero_ff};

endmodule : isolated_pixel_counter

`default_nettype wire

// ===== rtl/ipc_checker.sv =====
// ----------------------------------------------------------------------------
// Isolated pixel counter checker
// Port-level assertions on the count response channel, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ipc_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [ipc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int TW = ipc_pkg::TALLY_W;

   logic [31:0] count_sum;

   assign count_sum = 32'(rsp_tdata[TW-1:0]) + 32'(rsp_tdata[2*TW-1:TW]);

   // hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response dropped or changed");

   // no response right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // both counts together never exceed the interior pixel count of the largest image
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> count_sum <= 32'(ipc_pkg::MAX_INTERIOR))
      else $error("counts exceed interior pixel count");

   // a response appears only after a pixel request was taken
   assert property (@(posedge clock) disable iff (reset)
      !$past(rsp_tvalid) && rsp_tvalid |-> $past(req_tvalid && req_tready))
      else $error("response without a preceding pixel request");

endmodule : ipc_checker

bind isolated_pixel_counter ipc_checker u_ipc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
